@@ rtl/core/fdht_pkg.sv @@
//------------------------------------------------------------------------------
// fdht_pkg
// Shared types and constants for the frame deframer with host table.
//------------------------------------------------------------------------------
`default_nettype none
package fdht_pkg;
	localparam int HostSlots  = 4;
	localparam int FrameBytes = 16;
	localparam int SlotW      = $clog2(HostSlots);
	localparam int CntW       = $clog2(HostSlots + 1);
	localparam int FillW      = $clog2(FrameBytes + 1);
	localparam int QDepth     = 2;

	localparam logic [7:0] MagicByte   = 8'h53;
	localparam logic [7:0] VersionByte = 8'h01;

	typedef enum logic [1:0] {
		REQ_BYTE = 2'd0,
		REQ_CONN = 2'd1,
		REQ_DISC = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [7:0] {
		FK_MOUSE = 8'd1,
		FK_ENTER = 8'd2,
		FK_LEAVE = 8'd3,
		FK_PING  = 8'd4
	} frame_kind_t;

	typedef enum logic [2:0] {
		RK_MOUSE   = 3'd0,
		RK_RELEASE = 3'd1,
		RK_ENTER   = 3'd2,
		RK_PING    = 3'd3,
		RK_CONN    = 3'd4,
		RK_FULL    = 3'd5,
		RK_DISC    = 3'd6
	} result_kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  rx_byte;
		logic [15:0] link_id;
		logic [47:0] peer_mac;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic [15:0]        target_link;
		logic [7:0]         buttons;
		logic signed [15:0] move_x;
		logic signed [15:0] move_y;
		logic signed [7:0]  wheel;
		logic signed [7:0]  pan;
		logic [7:0]         node;
		logic [7:0]         edge_res;
		logic [15:0]        sequence_res;
		logic [2:0]         host_count;
		logic               restart_advertising;
	} out_item_t;

	// classified work for the back part
	typedef struct packed {
		logic        is_frame;
		logic        is_conn;
		logic        is_disc;
		logic [7:0]  kind;
		logic [7:0]  node;
		logic [15:0] seq;
		logic [7:0]  b6;
		logic [15:0] mx;
		logic [15:0] my;
		logic [7:0]  wh;
		logic [7:0]  pn;
		logic [15:0] link_id;
		logic [47:0] peer_mac;
	} cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/fdht_if.sv @@
//------------------------------------------------------------------------------
// fdht_if
// Valid/ready channel carrying one payload item.
//------------------------------------------------------------------------------
`default_nettype none
interface fdht_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/fdht_front.sv @@
//------------------------------------------------------------------------------
// fdht_front
// Byte window, magic/version check and request classification.
//------------------------------------------------------------------------------
`default_nettype none
module fdht_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  fdht_pkg::in_item_t     in_data,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output fdht_pkg::cmd_t         cmd
);
	import fdht_pkg::*;

	logic [7:0]       win_q [FrameBytes];
	logic [FillW-1:0] fill_q;
	logic [7:0]       nw [FrameBytes];
	logic             take;
	logic             full;
	logic             match;

	assign in_ready = cmd_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < FrameBytes; i++) begin
			nw[i] = win_q[i];
		end
		nw[FrameBytes-1] = in_data.rx_byte;
		for (int i = 0; i < FrameBytes - 1; i++) begin
			if (fill_q == FillW'(i)) begin
				nw[i] = in_data.rx_byte;
			end
		end
	end

	assign full  = (fill_q == FillW'(FrameBytes - 1));
	assign match = (nw[0] == MagicByte) && (nw[1] == VersionByte);

	always_ff @(posedge clk) begin
		if (take && in_data.req_type == REQ_BYTE) begin
			if (full && !match) begin
				for (int i = 0; i < FrameBytes - 1; i++) begin
					win_q[i] <= nw[i+1];
				end
			end else begin
				for (int i = 0; i < FrameBytes; i++) begin
					win_q[i] <= nw[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take && in_data.req_type == REQ_BYTE) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end else if (match) begin
				fill_q <= '0;
			end
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.kind      = nw[2];
		cmd.node      = nw[3];
		cmd.seq       = {nw[5], nw[4]};
		cmd.b6        = nw[6];
		cmd.mx        = {nw[9], nw[8]};
		cmd.my        = {nw[11], nw[10]};
		cmd.wh        = nw[12];
		cmd.pn        = nw[13];
		cmd.link_id   = in_data.link_id;
		cmd.peer_mac  = in_data.peer_mac;
		case (req_t'(in_data.req_type))
			REQ_BYTE: cmd.is_frame = full && match;
			REQ_CONN: cmd.is_conn = 1'b1;
			REQ_DISC: cmd.is_disc = 1'b1;
			default:  cmd.is_frame = 1'b0;
		endcase
		cmd_valid = in_valid && (cmd.is_frame || cmd.is_conn || cmd.is_disc);
	end
endmodule
`default_nettype wire

@@ rtl/core/fdht_queue.sv @@
//------------------------------------------------------------------------------
// fdht_queue
// Short command queue between front and back.
//------------------------------------------------------------------------------
`default_nettype none
module fdht_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  fdht_pkg::cmd_t     wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output fdht_pkg::cmd_t     rd_data
);
	import fdht_pkg::*;

	cmd_t                  mem_q [QDepth];
	logic [$clog2(QDepth)-1:0] wp_q, rp_q;
	logic [$clog2(QDepth):0]   cnt_q;
	logic                  wr, rd;

	assign wr_ready = (cnt_q != ($clog2(QDepth)+1)'(QDepth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/fdht_back.sv @@
//------------------------------------------------------------------------------
// fdht_back
// Sequence gate, host table and result register.
//------------------------------------------------------------------------------
`default_nettype none
module fdht_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  fdht_pkg::cmd_t     cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output fdht_pkg::out_item_t out_data
);
	import fdht_pkg::*;

	logic                 seq_valid_q;
	logic [15:0]          seq_latest_q;
	logic [HostSlots-1:0] busy_q;
	logic [15:0]          link_q [HostSlots];
	logic [47:0]          peer_q [HostSlots];
	logic                 ov_q;
	out_item_t            od_q;

	logic                 take, gate_ok, bound, emit;
	logic [15:0]          d;
	logic [15:0]          blink;
	logic [HostSlots-1:0] busy_n;
	logic [SlotW-1:0]     free_i, hit_i;
	logic                 free_f, hit_f;
	out_item_t            r;

	assign cmd_ready = !ov_q || out_ready;
	assign take      = cmd_valid && cmd_ready;
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign d         = cmd.seq - seq_latest_q;
	assign gate_ok   = !seq_valid_q || (d != 16'd0 && !d[15]);

	always_comb begin
		free_f = 1'b0;
		free_i = '0;
		hit_f  = 1'b0;
		hit_i  = '0;
		bound  = 1'b0;
		blink  = '0;
		for (int i = HostSlots - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_f = 1'b1;
				free_i = SlotW'(i);
			end
			if (busy_q[i] && peer_q[i] == cmd.peer_mac) begin
				hit_f = 1'b1;
				hit_i = SlotW'(i);
			end
			if (busy_q[i] && cmd.node == 8'(i + 1)) begin
				bound = 1'b1;
				blink = link_q[i];
			end
		end
		busy_n = busy_q;
		if (cmd.is_conn && free_f) begin
			busy_n[free_i] = 1'b1;
		end
		if (cmd.is_disc && hit_f) begin
			busy_n[hit_i] = 1'b0;
		end
	end

	always_comb begin
		r          = '0;
		emit       = 1'b0;
		r.host_count = CntW'($countones(busy_n));
		if (cmd.is_conn) begin
			emit = 1'b1;
			r.target_link = cmd.link_id;
			r.result_kind = free_f ? RK_CONN : RK_FULL;
			r.restart_advertising = (r.host_count < 3'(HostSlots));
		end else if (cmd.is_disc) begin
			emit = 1'b1;
			r.result_kind = RK_DISC;
			r.target_link = hit_f ? link_q[hit_i] : 16'd0;
			r.restart_advertising = 1'b1;
		end else if (cmd.is_frame && gate_ok) begin
			r.target_link  = blink;
			r.node         = cmd.node;
			r.sequence_res = cmd.seq;
			case (frame_kind_t'(cmd.kind))
				FK_MOUSE: begin
					emit = bound;
					r.result_kind = RK_MOUSE;
					r.buttons = cmd.b6;
					r.move_x = cmd.mx;
					r.move_y = cmd.my;
					r.wheel = cmd.wh;
					r.pan = cmd.pn;
				end
				FK_LEAVE: begin
					emit = bound;
					r.result_kind = RK_RELEASE;
				end
				FK_ENTER: begin
					emit = bound;
					r.result_kind = RK_ENTER;
					r.edge_res = cmd.b6;
				end
				FK_PING: begin
					emit = 1'b1;
					r.result_kind = RK_PING;
				end
				default: emit = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.is_conn && free_f) begin
			link_q[free_i] <= cmd.link_id;
			peer_q[free_i] <= cmd.peer_mac;
		end
		if (take && emit) begin
			od_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q  <= 1'b0;
			seq_latest_q <= '0;
			busy_q       <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= busy_n;
				if (cmd.is_frame && gate_ok) begin
					seq_valid_q  <= 1'b1;
					seq_latest_q <= cmd.seq;
				end
				ov_q <= emit;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/frame_deframer_with_host_table.sv @@
//------------------------------------------------------------------------------
// frame_deframer_with_host_table
// Serial frame deframer with a host connection table.
//
//   channel  dir  payload
//   req      in   req_type, rx_byte, link_id, peer_mac
//   rsp      out  result_kind .. restart_advertising
//
// One item per cycle while the result is not stalled. Front registers the
// byte window; a two-entry queue feeds the back, which registers the table
// update and the result. Reset clears window fill, sequence gate, slot
// busy bits, queue and result valid. A stalled result holds and backs up
// the queue, then the input.
//------------------------------------------------------------------------------
`default_nettype none
module frame_deframer_with_host_table (
	input  wire logic clk,
	input  wire logic arst_n,
	fdht_if.sink      req,
	fdht_if.source    rsp
);
	import fdht_pkg::*;

	logic f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, b_cmd;

	fdht_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	fdht_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	fdht_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);
endmodule
`default_nettype wire
